>>> design/rpn_pkg.sv
// shared types and constants for the rpn evaluator
`timescale 1ns / 1ps
package rpn_pkg;
  localparam int StackDepthDefault = 128;
  localparam int QueueDepth = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  // classified command kinds
  localparam logic [2:0] K_PUSH = 3'd0;
  localparam logic [2:0] K_ADD  = 3'd1;
  localparam logic [2:0] K_SUB  = 3'd2;
  localparam logic [2:0] K_MUL  = 3'd3;
  localparam logic [2:0] K_DIV  = 3'd4;
  localparam logic [2:0] K_EQ   = 3'd5;
  localparam logic [2:0] K_END  = 3'd6;
  localparam logic [2:0] K_BAD  = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
  } cmd_t;
endpackage

>>> design/rpn_stack_evaluator.sv
// top level of the rpn evaluator
`timescale 1ns / 1ps
// Reverse Polish evaluator taking one ASCII character per request. The front
// end decodes characters into a two-entry command queue and drops spaces;
// the back end keeps the stack top in a register and the rest in a
// simple dual-port RAM. Digits and result-producing characters finish in
// idle; + and - go through RAM-read and execute states, * adds one multiply
// stage, and / waits on the 32-bit divider, which resolves one quotient bit
// per cycle. A result waits in an output register and holds back only the
// next command. No clearing pass: stack entries are only read once written.
module rpn_stack_evaluator #(
  parameter int StackDepth = rpn_pkg::StackDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);
  logic          cmd_valid, cmd_ready;
  rpn_pkg::cmd_t cmd;

  rpn_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_symbol(in_symbol), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  rpn_back #(.StackDepth(StackDepth)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  // error results never carry a value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rpn_pkg::ST_OK |-> out_value == '0)
    else $error("error result with nonzero value");

  // a result ends with an empty stack
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> u_back.dep_r == '0)
    else $error("stack not cleared on result");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= rpn_pkg::ST_DIVZERO)
    else $error("bad status code");
endmodule

>>> design/rpn_ram.sv
// generic simple dual port ram (one write, one read port) with registered read
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/rpn_front.sv
// front end: classifies characters and queues commands
`timescale 1ns / 1ps
module rpn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_symbol,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rpn_pkg::cmd_t     cmd
);
  localparam int PW = $clog2(rpn_pkg::QueueDepth);

  rpn_pkg::cmd_t   q_r [rpn_pkg::QueueDepth];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  rpn_pkg::cmd_t   cls;
  logic            keep;
  logic            push, pop;

  // character decode
  always_comb begin
    cls.digit = 4'd0;
    keep = 1'b1;
    if (in_symbol >= rpn_pkg::CH_ZERO && in_symbol <= rpn_pkg::CH_NINE) begin
      cls.kind  = rpn_pkg::K_PUSH;
      cls.digit = 4'(in_symbol - rpn_pkg::CH_ZERO);
    end else begin
      unique case (in_symbol)
        rpn_pkg::CH_PLUS:  cls.kind = rpn_pkg::K_ADD;
        rpn_pkg::CH_MINUS: cls.kind = rpn_pkg::K_SUB;
        rpn_pkg::CH_STAR:  cls.kind = rpn_pkg::K_MUL;
        rpn_pkg::CH_SLASH: cls.kind = rpn_pkg::K_DIV;
        rpn_pkg::CH_EQ:    cls.kind = rpn_pkg::K_EQ;
        rpn_pkg::CH_NUL:   cls.kind = rpn_pkg::K_END;
        rpn_pkg::CH_SPACE: begin
          cls.kind = rpn_pkg::K_BAD;
          keep = 1'b0;
        end
        default:           cls.kind = rpn_pkg::K_BAD;
      endcase
    end
  end

  assign in_ready  = (cnt_r != (PW+1)'(rpn_pkg::QueueDepth));
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  // command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= PW'((32'(wp_r) + 1) % rpn_pkg::QueueDepth);
      if (pop)  rp_r <= PW'((32'(rp_r) + 1) % rpn_pkg::QueueDepth);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

>>> design/rpn_div.sv
// iterative signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rpn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem_r, q_r, d_r;
  logic [5:0]  cnt_r;
  logic        busy_r, neg_r, done_r;
  logic [32:0] trial;
  logic [31:0] rsh;

  assign rsh   = {rem_r[30:0], q_r[31]};
  assign trial = {1'b0, rsh} - {1'b0, d_r};
  assign done  = done_r;
  assign quo   = neg_r ? (32'd0 - q_r) : q_r;

  // restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num[31] ? (32'd0 - num) : num;
      d_r   <= den[31] ? (32'd0 - den) : den;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rsh;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

>>> design/rpn_back.sv
// back end: stack sequencer, alu and result register
`timescale 1ns / 1ps
module rpn_back #(
  parameter int StackDepth = rpn_pkg::StackDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  rpn_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);
  localparam int AW = $clog2(StackDepth);
  localparam int DW = $clog2(StackDepth + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXE  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [DW-1:0] dep_r;
  logic [2:0]    kind_r;
  logic [31:0]   top_r, prod_r;
  logic          ov_r;
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;
  logic          div_start, div_done;
  logic [31:0]   quo;
  logic          emit;
  logic [31:0]   emit_val;
  logic [2:0]    emit_st;
  logic          take;

  // top of stack lives in top_r, ram holds the entries below it
  rpn_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rpn_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(rdata), .den(top_r),
    .done(div_done), .quo(quo)
  );

  assign take      = cmd_valid && cmd_ready;
  assign cmd_ready = (st_r == S_IDLE) && !(out_valid && !out_ready);
  assign raddr     = AW'(dep_r - DW'(2));
  // spill the old top when pushing onto a non-empty, non-full stack
  assign we        = take && cmd.kind == rpn_pkg::K_PUSH && dep_r != '0
                     && dep_r != DW'(StackDepth);
  assign waddr     = AW'(dep_r - DW'(1));
  assign wdata     = top_r;
  assign div_start = (st_r == S_EXE) && kind_r == rpn_pkg::K_DIV && top_r != '0;

  // command sequencer
  always_comb begin
    st_nxt   = st_r;
    emit     = 1'b0;
    emit_val = '0;
    emit_st  = rpn_pkg::ST_OK;
    unique case (st_r)
      S_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            rpn_pkg::K_PUSH: begin
              if (dep_r == DW'(StackDepth)) begin
                emit = 1'b1;
                emit_st = rpn_pkg::ST_OVERFLOW;
              end
            end
            rpn_pkg::K_ADD, rpn_pkg::K_SUB, rpn_pkg::K_MUL, rpn_pkg::K_DIV: begin
              if (dep_r < DW'(2)) begin
                emit = 1'b1;
                emit_st = rpn_pkg::ST_UNDERFLOW;
              end else begin
                st_nxt = S_RD;
              end
            end
            rpn_pkg::K_EQ: begin
              emit = 1'b1;
              if (dep_r == '0) emit_st = rpn_pkg::ST_UNDERFLOW;
              else emit_val = top_r;
            end
            rpn_pkg::K_END: emit = 1'b1;
            default: begin
              emit = 1'b1;
              emit_st = rpn_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_RD: st_nxt = S_EXE;
      S_EXE: begin
        if (kind_r == rpn_pkg::K_DIV) begin
          if (top_r == '0) begin
            emit = 1'b1;
            emit_st = rpn_pkg::ST_DIVZERO;
            st_nxt = S_IDLE;
          end else begin
            st_nxt = S_DIV;
          end
        end else if (kind_r == rpn_pkg::K_MUL) begin
          st_nxt = S_MUL;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_DIV: if (div_done) st_nxt = S_IDLE;
      S_MUL: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) kind_r <= cmd.kind;
    if (st_r == S_EXE) prod_r <= rdata * top_r;
    // stack top update
    if (take && cmd.kind == rpn_pkg::K_PUSH) top_r <= 32'(cmd.digit);
    if (st_r == S_EXE && kind_r == rpn_pkg::K_ADD) top_r <= rdata + top_r;
    if (st_r == S_EXE && kind_r == rpn_pkg::K_SUB) top_r <= rdata - top_r;
    if (st_r == S_MUL) top_r <= prod_r;
    if (st_r == S_DIV && div_done) top_r <= quo;
    if (emit) begin
      out_value  <= emit_val;
      out_status <= emit_st;
    end
    if (!rst_n) begin
      st_r  <= S_IDLE;
      dep_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) dep_r <= '0;
      else if (take && cmd.kind == rpn_pkg::K_PUSH) dep_r <= dep_r + DW'(1);
      else if (st_r == S_EXE) dep_r <= dep_r - DW'(1);
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
endmodule
